// ===== hdl/cqr_pkg.sv =====
// ----------------------------------------------------------------------------
// cqr_pkg
// Shared constants, request and status codes, and cell control and status types for
// the circular queue with removal.
// ----------------------------------------------------------------------------
package cqr_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int WORD_W    = 31;
  localparam int REQ_W     = 2;
  localparam int STAT_W    = 2;

  localparam logic [REQ_W-1:0] REQ_INSERT  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DEQUEUE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic shift;
    logic wr;
    logic match_mode;
  } cell_ctl_t;

  typedef struct packed {
    logic              occ;
    logic              live;
    logic              hit;
    logic              pass;
    logic              stop;
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] hit_word;
  } cell_stat_t;

endpackage

// ===== hdl/cqr_cell.sv =====
// ----------------------------------------------------------------------------
// cqr_cell
// One queue slot: word, occupied and live flags, and a scan token that walks
// toward the tail one cell per cycle. Shifts take the neighbor's contents.
// ----------------------------------------------------------------------------
module cqr_cell
  import cqr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cell_ctl_t         ctl,
  input  logic              wr_sel,
  input  logic [WORD_W-1:0] wdata,
  input  logic [WORD_W-1:0] key,
  input  logic              tok_in,
  input  logic              nxt_occ,
  input  logic              nxt_live,
  input  logic [WORD_W-1:0] nxt_word,
  output cell_stat_t        stat
);

  logic              occ;
  logic              live;
  logic              tok;
  logic [WORD_W-1:0] word;
  logic              hit;

  assign hit = tok & live & (!ctl.match_mode | (word == key));

  always_ff @(posedge clk) begin
    if (rst) begin
      occ  <= 1'b0;
      live <= 1'b0;
      tok  <= 1'b0;
    end else begin
      tok <= tok_in;
      if (ctl.shift) begin
        occ  <= nxt_occ;
        live <= nxt_live;
      end else if (ctl.wr && wr_sel) begin
        occ  <= 1'b1;
        live <= 1'b1;
      end else if (hit && ctl.match_mode) begin
        live <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      word <= nxt_word;
    end else if (ctl.wr && wr_sel) begin
      word <= wdata;
    end
  end

  assign stat.occ      = occ;
  assign stat.live     = live;
  assign stat.hit      = hit;
  assign stat.pass     = tok & occ & !hit;
  assign stat.stop     = tok & !occ;
  assign stat.word     = word;
  assign stat.hit_word = hit ? word : '0;

endmodule

// ===== hdl/circular_queue_with_removal_unit.sv =====
// ----------------------------------------------------------------------------
// circular_queue_with_removal_unit
// FIFO of 31-bit words with insert, dequeue and remove-by-value, built as a
// row of slot cells with the head at cell 0.
//
//   channel | dir | handshake           | payload
//   in      | in  | in_valid / in_stall | req_type, data_in
//   out     | out | out_valid/out_stall | status, data_out, live_count,
//           |     |                     | head_data, is_empty
//
// One item at a time. Insert and unknown requests run a head scan; dequeue
// first shifts out the leading removed slots and the taken word, then runs
// the head scan; remove runs a search scan, then the head scan. Each scan
// walks at most DEPTH cells: the scan token moves one cell per cycle.
// Reset empties every cell; a result held by out_stall holds the next item
// in the finishing state.
// ----------------------------------------------------------------------------
module circular_queue_with_removal_unit
  import cqr_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [REQ_W-1:0]  req_type,
  input  logic [WORD_W-1:0] data_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [STAT_W-1:0] status,
  output logic [WORD_W-1:0] data_out,
  output logic [CNT_W-1:0]  live_count,
  output logic [WORD_W-1:0] head_data,
  output logic              is_empty
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SHIFT = 4'b0010,
    S_SCAN  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  used;
  logic [CNT_W-1:0]  live_cnt;
  logic [WORD_W-1:0] key;
  logic [STAT_W-1:0] res_status;
  logic [WORD_W-1:0] taken;
  logic [WORD_W-1:0] head;
  logic              match_mode;

  cell_ctl_t         ctl;
  cell_stat_t        stat [DEPTH];
  logic [DEPTH-1:0]  tok_in;
  logic [DEPTH-1:0]  hits;
  logic [DEPTH-1:0]  stops;
  logic [DEPTH-1:0]  toks;
  logic [WORD_W-1:0] hit_word;
  logic              accept;
  logic              full;
  logic              scan_end;
  logic              any_hit;
  logic              start;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign full     = (used == CNT_W'(DEPTH));

  always_comb begin
    hit_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_word = hit_word | stat[i].hit_word;
      hits[i]  = stat[i].hit;
      stops[i] = stat[i].stop;
      toks[i]  = stat[i].pass | stat[i].hit | stat[i].stop;
    end
  end

  assign any_hit  = |hits;
  assign scan_end = any_hit | (|stops) | stat[DEPTH-1].pass;

  // token restarts at the head: after any accepted item but dequeue,
  // after the dequeue shift, and between the search and the head scan
  always_comb begin
    start = 1'b0;
    unique case (state)
      S_IDLE:  start = accept && (req_type != REQ_DEQUEUE);
      S_SHIFT: start = (used == '0) || stat[0].live;
      S_SCAN:  start = scan_end && match_mode;
      S_DONE:  start = 1'b0;
      default: start = 1'b0;
    endcase
  end

  assign ctl.shift      = (state == S_SHIFT) && (used != '0);
  assign ctl.wr         = accept && (req_type == REQ_INSERT) && !full;
  assign ctl.match_mode = match_mode;

  assign tok_in[0] = start;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      if (g > 0) begin : g_tok
        assign tok_in[g] = stat[g-1].pass && (state == S_SCAN) && !scan_end;
      end
      if (g < DEPTH - 1) begin : g_mid
        cqr_cell u_cell (
          .clk      (clk),
          .rst      (rst),
          .ctl      (ctl),
          .wr_sel   (used == CNT_W'(g)),
          .wdata    (data_in),
          .key      (key),
          .tok_in   (tok_in[g]),
          .nxt_occ  (stat[g+1].occ),
          .nxt_live (stat[g+1].live),
          .nxt_word (stat[g+1].word),
          .stat     (stat[g])
        );
      end else begin : g_last
        cqr_cell u_cell (
          .clk      (clk),
          .rst      (rst),
          .ctl      (ctl),
          .wr_sel   (used == CNT_W'(g)),
          .wdata    (data_in),
          .key      (key),
          .tok_in   (tok_in[g]),
          .nxt_occ  (1'b0),
          .nxt_live (1'b0),
          .nxt_word ('0),
          .stat     (stat[g])
        );
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used       <= '0;
      live_cnt   <= '0;
      match_mode <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            key        <= data_in;
            taken      <= '0;
            res_status <= ST_OK;
            match_mode <= 1'b0;
            state      <= S_SCAN;
            case (req_type)
              REQ_INSERT: begin
                if (full) begin
                  res_status <= ST_FULL;
                end else begin
                  used     <= used + 1'b1;
                  live_cnt <= live_cnt + 1'b1;
                end
              end
              REQ_DEQUEUE: state <= S_SHIFT;
              REQ_REMOVE: begin
                res_status <= ST_NOT_FOUND;
                match_mode <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        S_SHIFT: begin
          if (used == '0) begin
            res_status <= ST_EMPTY;
            live_cnt   <= '0;
            state      <= S_SCAN;
          end else begin
            used <= used - 1'b1;
            if (stat[0].live) begin
              taken <= stat[0].word;
              if (live_cnt != '0) begin
                live_cnt <= live_cnt - 1'b1;
              end
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_end) begin
            if (match_mode) begin
              match_mode <= 1'b0;
              if (any_hit) begin
                res_status <= ST_OK;
                if (live_cnt != '0) begin
                  live_cnt <= live_cnt - 1'b1;
                end
              end
            end else begin
              head  <= hit_word;
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            status     <= res_status;
            data_out   <= taken;
            live_count <= live_cnt;
            head_data  <= head;
            is_empty   <= (live_cnt == '0);
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_used_range: assert property (@(posedge clk) disable iff (rst)
    used <= CNT_W'(DEPTH))
    else $error("occupied count beyond depth");

  a_live_le_used: assert property (@(posedge clk) disable iff (rst)
    live_cnt <= used)
    else $error("live count above occupied count");

  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(toks))
    else $error("more than one scan token in the cell row");

  a_token_in_scan: assert property (@(posedge clk) disable iff (rst)
    (toks != '0) |-> (state == S_SCAN))
    else $error("scan token outside of a scan");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("accepted item did not start work");

endmodule

// ===== bench/circular_queue_with_removal_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_queue_with_removal_unit_test
// Self-checking bench for the circular queue with removal. A directed table
// covers the empty, full, wrap and removed-only cases, then random
// insert/dequeue/remove traffic runs with random idle bursts on both
// channels. Each result is compared with its table row or a ring-buffer predictor.
// ----------------------------------------------------------------------------
module circular_queue_with_removal_unit_test;
  import cqr_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam logic [WORD_W-1:0] WORD_MAX = {WORD_W{1'b1}};
  localparam int RANDOM_ITEMS = 650;
  localparam int CALM_ITEMS = 100;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 16;
  localparam int WAIT_LIMIT = 20000;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [WORD_W-1:0] data_out;
    logic [CNT_W-1:0]  live_count;
    logic [WORD_W-1:0] head_data;
    logic              is_empty;
  } outcome_t;

  typedef struct {
    logic [REQ_W-1:0]  req;
    logic [WORD_W-1:0] word;
    bit                typed;
    outcome_t          want;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid;
  logic              in_stall;
  logic [REQ_W-1:0]  req_type;
  logic [WORD_W-1:0] data_in;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [STAT_W-1:0] status;
  logic [WORD_W-1:0] data_out;
  logic [CNT_W-1:0]  live_count;
  logic [WORD_W-1:0] head_data;
  logic              is_empty;

  circular_queue_with_removal_unit #(.DEPTH(DEPTH)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .data_in(data_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .data_out(data_out), .live_count(live_count),
    .head_data(head_data), .is_empty(is_empty)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // predicted ring state
  logic [WORD_W-1:0] ring_word [DEPTH];
  bit                ring_live [DEPTH];
  int                head_idx, tail_idx, occupied, live_total;

  outcome_t pending_q [$];
  int fail_count = 0;
  int results_seen = 0;
  int req_seen [4];
  int status_seen [4];
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit calm = 1'b0;
  int stall_left = 0;
  outcome_t got_res, want_res;

  function automatic int ring_step(input int p);
    return (p + 1 >= DEPTH) ? 0 : p + 1;
  endfunction

  function automatic outcome_t serve_request(input logic [REQ_W-1:0] req,
                                             input logic [WORD_W-1:0] word);
    outcome_t res;
    int p;
    res = '0;
    case (req)
      REQ_INSERT: begin
        if (occupied >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          ring_word[tail_idx] = word;
          ring_live[tail_idx] = 1'b1;
          tail_idx = ring_step(tail_idx);
          occupied++;
          live_total++;
        end
      end
      REQ_DEQUEUE: begin
        while (occupied > 0 && !ring_live[head_idx]) begin
          head_idx = ring_step(head_idx);
          occupied--;
        end
        if (occupied == 0) begin
          res.status = ST_EMPTY;
          live_total = 0;
        end else begin
          res.data_out = ring_word[head_idx];
          ring_live[head_idx] = 1'b0;
          head_idx = ring_step(head_idx);
          occupied--;
          if (live_total > 0) live_total--;
        end
      end
      REQ_REMOVE: begin
        res.status = ST_NOT_FOUND;
        p = head_idx;
        for (int i = 0; i < occupied; i++) begin
          if (ring_live[p] && ring_word[p] == word) begin
            ring_live[p] = 1'b0;
            if (live_total > 0) live_total--;
            res.status = ST_OK;
            break;
          end
          p = ring_step(p);
        end
      end
      default: ;
    endcase
    res.live_count = live_total[CNT_W-1:0];
    p = head_idx;
    for (int i = 0; i < occupied; i++) begin
      if (ring_live[p]) begin
        res.head_data = ring_word[p];
        break;
      end
      p = ring_step(p);
    end
    res.is_empty = (live_total == 0);
    return res;
  endfunction

  function automatic stim_row_t make_row(input logic [REQ_W-1:0] req,
                                         input logic [WORD_W-1:0] word,
                                         input bit typed, input outcome_t want);
    stim_row_t r;
    r.req = req;
    r.word = word;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  // returns at the edge where the item is taken
  task automatic send_item(input stim_row_t row, input int gap);
    outcome_t pred;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= row.req;
    data_in <= row.word;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pred = serve_request(row.req, row.word);
    pending_q.push_back(row.typed ? row.want : pred);
    req_seen[row.req]++;
    status_seen[pred.status]++;
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  // result side: random stall bursts and checking
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (rx_idle_on && !calm && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_stall <= 1'b0;
    end
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      results_seen++;
      got_res.status = status;
      got_res.data_out = data_out;
      got_res.live_count = live_count;
      got_res.head_data = head_data;
      got_res.is_empty = is_empty;
      if (pending_q.size() == 0) begin
        $error("result with no request pending");
        fail_count++;
      end else begin
        want_res = pending_q.pop_front();
        if (got_res.status !== want_res.status) begin
          $error("status: expected %0d, got %0d", want_res.status, got_res.status);
          fail_count++;
        end
        if (got_res.data_out !== want_res.data_out) begin
          $error("data_out: expected %0h, got %0h", want_res.data_out, got_res.data_out);
          fail_count++;
        end
        if (got_res.live_count !== want_res.live_count) begin
          $error("live_count: expected %0d, got %0d",
                 want_res.live_count, got_res.live_count);
          fail_count++;
        end
        if (got_res.head_data !== want_res.head_data) begin
          $error("head_data: expected %0h, got %0h",
                 want_res.head_data, got_res.head_data);
          fail_count++;
        end
        if (got_res.is_empty !== want_res.is_empty) begin
          $error("is_empty: expected %0d, got %0d", want_res.is_empty, got_res.is_empty);
          fail_count++;
        end
      end
    end
  end

  initial begin
    stim_row_t tbl [$];
    stim_row_t row;
    int gap, mode, pick, ins_cut, deq_cut, p, waited;
    logic [REQ_W-1:0] req;
    logic [WORD_W-1:0] word;

    in_valid = 1'b0;
    req_type = REQ_INSERT;
    data_in = '0;
    for (int i = 0; i < DEPTH; i++) begin
      ring_live[i] = 1'b0;
      ring_word[i] = '0;
    end
    head_idx = 0;
    tail_idx = 0;
    occupied = 0;
    live_total = 0;
    for (int i = 0; i < 4; i++) begin
      req_seen[i] = 0;
      status_seen[i] = 0;
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // empty ring, unused request, removed-only ring, fill, full, wrap
    tbl.push_back(make_row(REQ_DEQUEUE, '0, 1'b1,
                           outcome_t'{ST_EMPTY, '0, '0, '0, 1'b1}));
    tbl.push_back(make_row(REQ_REMOVE, 31'd5, 1'b1,
                           outcome_t'{ST_NOT_FOUND, '0, '0, '0, 1'b1}));
    tbl.push_back(make_row(REQ_UNUSED, WORD_MAX, 1'b1,
                           outcome_t'{ST_OK, '0, '0, '0, 1'b1}));
    tbl.push_back(make_row(REQ_INSERT, WORD_MAX, 1'b1,
                           outcome_t'{ST_OK, '0, CNT_W'(1), WORD_MAX, 1'b0}));
    tbl.push_back(make_row(REQ_REMOVE, WORD_MAX, 1'b1,
                           outcome_t'{ST_OK, '0, '0, '0, 1'b1}));
    tbl.push_back(make_row(REQ_DEQUEUE, '0, 1'b1,
                           outcome_t'{ST_EMPTY, '0, '0, '0, 1'b1}));
    tbl.push_back(make_row(REQ_INSERT, '0, 1'b1,
                           outcome_t'{ST_OK, '0, CNT_W'(1), '0, 1'b0}));
    for (int k = 1; k < DEPTH; k++)
      tbl.push_back(make_row(REQ_INSERT, WORD_W'(32'h0123_4567 * k), 1'b0, '0));
    tbl.push_back(make_row(REQ_INSERT, 31'h2AAA_AAAA, 1'b1,
                           outcome_t'{ST_FULL, '0, CNT_W'(DEPTH), '0, 1'b0}));
    tbl.push_back(make_row(REQ_REMOVE, WORD_W'(32'h0123_4567 * (DEPTH - 1)), 1'b0, '0));
    tbl.push_back(make_row(REQ_REMOVE, '0, 1'b0, '0));
    tbl.push_back(make_row(REQ_DEQUEUE, '0, 1'b0, '0));
    tbl.push_back(make_row(REQ_UNUSED, 31'h5555_5555, 1'b0, '0));

    foreach (tbl[i]) begin
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
      send_item(tbl[i], gap);
    end
    wait_all_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        mode = $urandom_range(0, 2);
        tx_idle_on = ($urandom_range(0, 2) != 0);
        rx_idle_on = ($urandom_range(0, 2) != 0);
      end
      if (n == RANDOM_ITEMS / 2) wait_all_results();
      if (n >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;

      // fill-heavy, drain-heavy or balanced segments
      ins_cut = (mode == 0) ? 60 : (mode == 1) ? 25 : 40;
      deq_cut = (mode == 0) ? 75 : (mode == 1) ? 65 : 70;
      pick = $urandom_range(0, 99);
      if (pick < ins_cut) req = REQ_INSERT;
      else if (pick < deq_cut) req = REQ_DEQUEUE;
      else if (pick < 95) req = REQ_REMOVE;
      else req = REQ_UNUSED;

      case ($urandom_range(0, 3))
        0, 1: word = WORD_W'($urandom_range(0, 15));
        2: word = WORD_W'($urandom);
        default: begin
          case ($urandom_range(0, 2))
            0: word = '0;
            1: word = WORD_MAX;
            default: word = WORD_W'(1) << $urandom_range(0, WORD_W - 1);
          endcase
        end
      endcase
      // removals mostly target a word that is live right now
      if (req == REQ_REMOVE && $urandom_range(0, 9) < 7) begin
        p = $urandom_range(0, DEPTH - 1);
        for (int k = 0; k < DEPTH; k++) begin
          if (ring_live[p]) begin
            word = ring_word[p];
            break;
          end
          p = ring_step(p);
        end
      end

      gap = (tx_idle_on && !calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
      row = make_row(req, word, 1'b0, '0);
      send_item(row, gap);
    end
    in_valid <= 1'b0;

    waited = 0;
    while (pending_q.size() != 0 && waited < WAIT_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_q.size() != 0) begin
      $error("%0d results never arrived", pending_q.size());
      fail_count++;
    end

    $display("ran %0d inserts, %0d dequeues, %0d removals, %0d unused requests; %0d checked",
             req_seen[REQ_INSERT], req_seen[REQ_DEQUEUE], req_seen[REQ_REMOVE],
             req_seen[REQ_UNUSED], results_seen);
    $display("statuses: ok %0d, full %0d, empty %0d, not found %0d",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
             status_seen[ST_NOT_FOUND]);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
